FILE: rtl/sgt_pkg.sv
// Shared types, defaults and helpers for the skeleton global transform core.
package sgt_pkg;

    localparam int MAX_NODES_DEF = 256;
    localparam int FRAC_BITS_DEF = 16;

    typedef logic signed [31:0] fix_t;
    typedef logic signed [65:0] wide_t;

    localparam logic MOP_LOC = 1'b0;
    localparam logic MOP_GLB = 1'b1;

    typedef struct packed {
        logic       load;
        logic       rd_en;
        logic [1:0] row;
        logic       quat_en;
        logic       rot_en;
        logic       mul_en;
        logic       mul_op;
        logic [3:0] mul_idx;
        logic       out_load;
    } cmd_t;

    typedef struct packed {
        logic out_free;
    } sts_t;

    function automatic fix_t sat32(input wide_t v);
        fix_t r;
        if (v > 66'sd2147483647) begin
            r = 32'sh7fffffff;
        end else if (v < -66'sd2147483648) begin
            r = 32'sh80000000;
        end else begin
            r = fix_t'(v[31:0]);
        end
        return r;
    endfunction

endpackage

FILE: rtl/sgt_ctrl.sv
// Sequencing state machine for the skeleton global transform core.
module sgt_ctrl (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  sgt_pkg::sts_t sts,
    output sgt_pkg::cmd_t cmd
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_PRD  = 3'd1;
    localparam logic [2:0] ST_QUAT = 3'd2;
    localparam logic [2:0] ST_ROT  = 3'd3;
    localparam logic [2:0] ST_LOC  = 3'd4;
    localparam logic [2:0] ST_GLB  = 3'd5;
    localparam logic [2:0] ST_GDRN = 3'd6;
    localparam logic [2:0] ST_OUT  = 3'd7;

    logic [2:0] state_reg, state_next;
    logic [3:0] cnt_reg, cnt_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        cnt_next   = cnt_reg;
        s_ready    = (state_reg == ST_IDLE);
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_PRD;
                    cnt_next   = '0;
                end
            end
            ST_PRD: begin
                cmd.rd_en = 1'b1;
                cmd.row   = cnt_reg[1:0];
                if (cnt_reg == 4'd3) begin
                    state_next = ST_QUAT;
                    cnt_next   = '0;
                end else begin
                    cnt_next = cnt_reg + 4'd1;
                end
            end
            ST_QUAT: begin
                cmd.quat_en = 1'b1;
                state_next  = ST_ROT;
            end
            ST_ROT: begin
                cmd.rot_en = 1'b1;
                state_next = ST_LOC;
                cnt_next   = '0;
            end
            ST_LOC: begin
                cmd.mul_en  = 1'b1;
                cmd.mul_op  = sgt_pkg::MOP_LOC;
                cmd.mul_idx = cnt_reg;
                if (cnt_reg == 4'd2) begin
                    state_next = ST_GLB;
                    cnt_next   = '0;
                end else begin
                    cnt_next = cnt_reg + 4'd1;
                end
            end
            ST_GLB: begin
                cmd.mul_en  = 1'b1;
                cmd.mul_op  = sgt_pkg::MOP_GLB;
                cmd.mul_idx = cnt_reg;
                if (cnt_reg == 4'd15) begin
                    state_next = ST_GDRN;
                    cnt_next   = '0;
                end else begin
                    cnt_next = cnt_reg + 4'd1;
                end
            end
            ST_GDRN: begin
                state_next = ST_OUT;
                cnt_next   = '0;
            end
            ST_OUT: begin
                if (sts.out_free) begin
                    cmd.out_load = 1'b1;
                    cmd.row      = cnt_reg[1:0];
                    if (cnt_reg == 4'd3) begin
                        state_next = ST_IDLE;
                        cnt_next   = '0;
                    end else begin
                        cnt_next = cnt_reg + 4'd1;
                    end
                end
            end
        endcase
    end

    a_accept_starts_read: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> (state_reg == ST_PRD && cnt_reg == 4'd0))
        else $error("accepted transaction did not start the parent read");

    a_last_row_idles: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.out_load && cmd.row == 2'd3) |=> (state_reg == ST_IDLE))
        else $error("controller did not return to idle after the last row");

endmodule

FILE: rtl/sgt_datapath.sv
// Datapath with node table, quaternion, local and global matrix arithmetic.
module sgt_datapath #(
    parameter int MAX_NODES = sgt_pkg::MAX_NODES_DEF,
    parameter int FRAC_BITS = sgt_pkg::FRAC_BITS_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  sgt_pkg::cmd_t       cmd,
    output sgt_pkg::sts_t       sts,
    input  logic [7:0]          s_node_index,
    input  logic signed [8:0]   s_parent_node,
    input  logic signed [31:0]  s_scale_x,
    input  logic signed [31:0]  s_scale_y,
    input  logic signed [31:0]  s_scale_z,
    input  logic signed [17:0]  s_quat_x,
    input  logic signed [17:0]  s_quat_y,
    input  logic signed [17:0]  s_quat_z,
    input  logic signed [17:0]  s_quat_w,
    input  logic signed [31:0]  s_move_x,
    input  logic signed [31:0]  s_move_y,
    input  logic signed [31:0]  s_move_z,
    input  logic                m_ready,
    output logic                m_valid,
    output logic [7:0]          m_node_out,
    output logic [1:0]          m_row_number,
    output logic signed [31:0]  m_col0,
    output logic signed [31:0]  m_col1,
    output logic signed [31:0]  m_col2,
    output logic signed [31:0]  m_col3,
    output logic                m_last_row
);

    localparam int DEPTH  = MAX_NODES * 4;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam logic signed [31:0] ONE = 32'sd1 <<< FRAC_BITS;

    typedef logic signed [35:0] qprod_t;
    typedef logic signed [39:0] qsum_t;
    typedef logic signed [63:0] prod_t;

    logic [127:0] mem [DEPTH];

    logic [7:0]         node_reg;
    logic [7:0]         pidx_reg;
    logic               node_ok_reg;
    logic               par_ok_reg;
    sgt_pkg::fix_t      scale_reg [3];
    sgt_pkg::fix_t      move_reg [3];
    logic signed [17:0] qx_reg, qy_reg, qz_reg, qw_reg;

    logic [127:0]  rd_q_reg;
    logic          rd_vld_reg;
    logic [1:0]    rd_row_reg;
    sgt_pkg::fix_t par_reg [4][4];

    qprod_t        qp_reg [9];
    sgt_pkg::fix_t rot_reg [3][3];
    sgt_pkg::fix_t loc_reg [3][3];
    sgt_pkg::fix_t loc_m [4][4];
    sgt_pkg::fix_t glob_reg [4][4];

    sgt_pkg::fix_t ma [4];
    sgt_pkg::fix_t mb [4];
    prod_t         prod_reg [4];
    logic          mvld_reg;
    logic          mop_reg;
    logic [3:0]    midx_reg;
    sgt_pkg::wide_t sh [4];
    sgt_pkg::wide_t acc;

    logic              m_valid_reg;
    logic [7:0]        m_node_reg;
    logic [1:0]        m_row_reg;
    sgt_pkg::fix_t     m_col_reg [4];
    logic              m_last_reg;

    logic [31:0]       rd_addr_full, wr_addr_full;
    logic [ADDR_W-1:0] rd_addr, wr_addr;
    qsum_t             qs [9];
    logic [31:0]       node_wide, par_wide;

    assign node_wide    = {24'd0, s_node_index};
    assign par_wide     = {24'd0, s_parent_node[7:0]};
    assign rd_addr_full = {22'd0, pidx_reg, cmd.row};
    assign wr_addr_full = {22'd0, node_reg, cmd.row};
    assign rd_addr      = rd_addr_full[ADDR_W-1:0];
    assign wr_addr      = wr_addr_full[ADDR_W-1:0];

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            node_reg     <= s_node_index;
            pidx_reg     <= s_parent_node[7:0];
            node_ok_reg  <= (node_wide < 32'(MAX_NODES));
            par_ok_reg   <= !s_parent_node[8] && (par_wide < 32'(MAX_NODES));
            scale_reg[0] <= s_scale_x;
            scale_reg[1] <= s_scale_y;
            scale_reg[2] <= s_scale_z;
            move_reg[0]  <= s_move_x;
            move_reg[1]  <= s_move_y;
            move_reg[2]  <= s_move_z;
            qx_reg       <= s_quat_x;
            qy_reg       <= s_quat_y;
            qz_reg       <= s_quat_z;
            qw_reg       <= s_quat_w;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.rd_en) begin
            rd_q_reg <= mem[rd_addr];
        end
        rd_row_reg <= cmd.row;
        if (cmd.out_load && node_ok_reg) begin
            mem[wr_addr] <= {glob_reg[cmd.row][3], glob_reg[cmd.row][2],
                             glob_reg[cmd.row][1], glob_reg[cmd.row][0]};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_vld_reg <= 1'b0;
        end else begin
            rd_vld_reg <= cmd.rd_en;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_vld_reg) begin
            for (int c = 0; c < 4; c++) begin
                if (par_ok_reg) begin
                    par_reg[rd_row_reg][c] <= sgt_pkg::fix_t'(rd_q_reg[32*c +: 32]);
                end else begin
                    par_reg[rd_row_reg][c] <= (rd_row_reg == 2'(c)) ? ONE : '0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.quat_en) begin
            qp_reg[0] <= qx_reg * qx_reg;
            qp_reg[1] <= qy_reg * qy_reg;
            qp_reg[2] <= qz_reg * qz_reg;
            qp_reg[3] <= qx_reg * qy_reg;
            qp_reg[4] <= qx_reg * qz_reg;
            qp_reg[5] <= qy_reg * qz_reg;
            qp_reg[6] <= qx_reg * qw_reg;
            qp_reg[7] <= qy_reg * qw_reg;
            qp_reg[8] <= qz_reg * qw_reg;
        end
    end

    always_comb begin
        for (int n = 0; n < 9; n++) begin
            qs[n] = 40'(qp_reg[n] >>> FRAC_BITS);
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.rot_en) begin
            rot_reg[0][0] <= sgt_pkg::sat32(66'(40'(ONE) - ((qs[1] + qs[2]) <<< 1)));
            rot_reg[0][1] <= sgt_pkg::sat32(66'((qs[3] + qs[8]) <<< 1));
            rot_reg[0][2] <= sgt_pkg::sat32(66'((qs[4] - qs[7]) <<< 1));
            rot_reg[1][0] <= sgt_pkg::sat32(66'((qs[3] - qs[8]) <<< 1));
            rot_reg[1][1] <= sgt_pkg::sat32(66'(40'(ONE) - ((qs[0] + qs[2]) <<< 1)));
            rot_reg[1][2] <= sgt_pkg::sat32(66'((qs[5] + qs[6]) <<< 1));
            rot_reg[2][0] <= sgt_pkg::sat32(66'((qs[4] + qs[7]) <<< 1));
            rot_reg[2][1] <= sgt_pkg::sat32(66'((qs[5] - qs[6]) <<< 1));
            rot_reg[2][2] <= sgt_pkg::sat32(66'(40'(ONE) - ((qs[0] + qs[1]) <<< 1)));
        end
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            for (int k = 0; k < 3; k++) begin
                loc_m[i][k] = loc_reg[i][k];
            end
            loc_m[i][3] = '0;
            loc_m[3][i] = move_reg[i];
        end
        loc_m[3][3] = ONE;
    end

    always_comb begin
        for (int k = 0; k < 4; k++) begin
            ma[k] = '0;
            mb[k] = '0;
        end
        if (cmd.mul_op == sgt_pkg::MOP_LOC) begin
            for (int k = 0; k < 3; k++) begin
                ma[k] = scale_reg[cmd.mul_idx[1:0]];
                mb[k] = rot_reg[cmd.mul_idx[1:0]][k];
            end
        end else begin
            for (int k = 0; k < 4; k++) begin
                ma[k] = loc_m[cmd.mul_idx[3:2]][k];
                mb[k] = par_reg[k][cmd.mul_idx[1:0]];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.mul_en) begin
            for (int k = 0; k < 4; k++) begin
                prod_reg[k] <= ma[k] * mb[k];
            end
        end
        mop_reg  <= cmd.mul_op;
        midx_reg <= cmd.mul_idx;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mvld_reg <= 1'b0;
        end else begin
            mvld_reg <= cmd.mul_en;
        end
    end

    always_comb begin
        for (int k = 0; k < 4; k++) begin
            sh[k] = 66'(prod_reg[k] >>> FRAC_BITS);
        end
        acc = sh[0] + sh[1] + sh[2] + sh[3];
    end

    always_ff @(posedge aclk) begin
        if (mvld_reg) begin
            if (mop_reg == sgt_pkg::MOP_LOC) begin
                for (int k = 0; k < 3; k++) begin
                    loc_reg[midx_reg[1:0]][k] <= sgt_pkg::sat32(sh[k]);
                end
            end else begin
                glob_reg[midx_reg[3:2]][midx_reg[1:0]] <= sgt_pkg::sat32(acc);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            m_node_reg <= node_reg;
            m_row_reg  <= cmd.row;
            m_last_reg <= (cmd.row == 2'd3);
            for (int c = 0; c < 4; c++) begin
                m_col_reg[c] <= glob_reg[cmd.row][c];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    assign sts.out_free  = !m_valid_reg || m_ready;
    assign m_valid       = m_valid_reg;
    assign m_node_out    = m_node_reg;
    assign m_row_number  = m_row_reg;
    assign m_col0        = m_col_reg[0];
    assign m_col1        = m_col_reg[1];
    assign m_col2        = m_col_reg[2];
    assign m_col3        = m_col_reg[3];
    assign m_last_row    = m_last_reg;

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> (!m_valid_reg || m_ready))
        else $error("result register loaded while a transaction was pending");

    a_valid_from_load: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(cmd.out_load))
        else $error("result valid raised without a load");

endmodule

FILE: rtl/skeleton_global_transform_core.sv
// Top level of the skeleton global transform core.
// Each transaction runs these steps in order: 4 parent
// table reads, quaternion and rotation stages, 3 local and 16 global passes of
// the shared four-lane multiplier, then four result rows.
// The result rows leave one per cycle while the result side is ready.
// Reset (synchronous, active low) clears control only; the node table is unset.
module skeleton_global_transform_core #(
    parameter int MAX_NODES = sgt_pkg::MAX_NODES_DEF,
    parameter int FRAC_BITS = sgt_pkg::FRAC_BITS_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [7:0]         s_node_index,
    input  logic signed [8:0]  s_parent_node,
    input  logic signed [31:0] s_scale_x,
    input  logic signed [31:0] s_scale_y,
    input  logic signed [31:0] s_scale_z,
    input  logic signed [17:0] s_quat_x,
    input  logic signed [17:0] s_quat_y,
    input  logic signed [17:0] s_quat_z,
    input  logic signed [17:0] s_quat_w,
    input  logic signed [31:0] s_move_x,
    input  logic signed [31:0] s_move_y,
    input  logic signed [31:0] s_move_z,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [7:0]         m_node_out,
    output logic [1:0]         m_row_number,
    output logic signed [31:0] m_col0,
    output logic signed [31:0] m_col1,
    output logic signed [31:0] m_col2,
    output logic signed [31:0] m_col3,
    output logic               m_last_row
);

    sgt_pkg::cmd_t cmd;
    sgt_pkg::sts_t sts;

    sgt_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    sgt_datapath #(
        .MAX_NODES (MAX_NODES),
        .FRAC_BITS (FRAC_BITS)
    ) u_datapath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .sts           (sts),
        .s_node_index  (s_node_index),
        .s_parent_node (s_parent_node),
        .s_scale_x     (s_scale_x),
        .s_scale_y     (s_scale_y),
        .s_scale_z     (s_scale_z),
        .s_quat_x      (s_quat_x),
        .s_quat_y      (s_quat_y),
        .s_quat_z      (s_quat_z),
        .s_quat_w      (s_quat_w),
        .s_move_x      (s_move_x),
        .s_move_y      (s_move_y),
        .s_move_z      (s_move_z),
        .m_ready       (m_ready),
        .m_valid       (m_valid),
        .m_node_out    (m_node_out),
        .m_row_number  (m_row_number),
        .m_col0        (m_col0),
        .m_col1        (m_col1),
        .m_col2        (m_col2),
        .m_col3        (m_col3),
        .m_last_row    (m_last_row)
    );

endmodule
